// ----- hdl/keyboard_layout_key_translator_core_defines.svh -----
// Assertion macros for the checker file of the key translator.
`ifndef KEYBOARD_LAYOUT_KEY_TRANSLATOR_CORE_DEFINES_SVH
`define KEYBOARD_LAYOUT_KEY_TRANSLATOR_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define KLKT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define KLKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/klkt_pkg.sv -----
// Shared types, codes and constants of the key translator.
package klkt_pkg;

  localparam int unsigned ENTRIES_DEF   = 128;
  localparam int unsigned CODE_BITS_DEF = 21;
  localparam int unsigned IDX_W         = 7;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned APB_DW        = 32;

  localparam int unsigned LETTER_COUNT  = 26;
  localparam int unsigned CTRL_OFFSET   = 96;
  localparam int unsigned CTRL_LIMIT    = 31;
  localparam int unsigned CODE_SPACE    = 32;
  localparam int unsigned CODE_NEWLINE  = 10;

  localparam int unsigned REG_TABLES_EN = 0;
  localparam int unsigned REG_CTRL_MODE = 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_SRC = 2'd0,
    MODE_WR_TGT = 2'd1,
    MODE_FWD    = 2'd2,
    MODE_BWD    = 2'd3
  } klkt_mode_e;

  typedef struct packed {
    logic src_we;
    logic tgt_we;
  } klkt_wr_t;

  function automatic int unsigned byte_round(input int unsigned bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

// ----- hdl/klkt_tables.sv -----
// Source and target layout tables: one write port each, shared read address.
module klkt_tables #(
  parameter int unsigned ENTRIES   = klkt_pkg::ENTRIES_DEF,
  parameter int unsigned CODE_BITS = klkt_pkg::CODE_BITS_DEF,
  localparam int unsigned AW       = $clog2(ENTRIES)
) (
  input  logic                 clk_i,
  input  klkt_pkg::klkt_wr_t   wr_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [CODE_BITS-1:0] wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [CODE_BITS-1:0] src_rd_o,
  output logic [CODE_BITS-1:0] tgt_rd_o
);

  logic [CODE_BITS-1:0] src_mem [ENTRIES];
  logic [CODE_BITS-1:0] tgt_mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_i.src_we) begin
      src_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      src_rd_o <= src_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.tgt_we) begin
      tgt_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      tgt_rd_o <= tgt_mem[rd_addr_i];
    end
  end

endmodule

// ----- hdl/keyboard_layout_key_translator_core.sv -----
// Top level of the keyboard layout key translator.
//
//  channel  dir  handshake                      contents
//  s_axis   in   tvalid/tready                  tuser: mode; tdata: entry_index, code
//  m_axis   out  tvalid/tready                  tdata: result_code
//  apb      in   psel/penable/pwrite, pready=1  tables_enabled @0, ctrl_key_mode @4
//
// A write transaction lands in the table while the block stays idle.
// A convert that needs a lookup scans the table memories, one entry per cycle over
// their single read port, then passes through ST_LAST to ST_DONE.
// A convert that passes its key through goes from idle straight to ST_DONE.
// After reset a clearing pass zeroes every entry of both tables; s_axis_tready
// stays low meanwhile, while register writes are taken as ever.
// A result waits in the output register; a stalled m_axis holds the block before its
// next result, not while it accepts the transaction that leads to it.
module keyboard_layout_key_translator_core #(
  parameter int unsigned ENTRIES    = klkt_pkg::ENTRIES_DEF,
  parameter int unsigned CODE_BITS  = klkt_pkg::CODE_BITS_DEF,
  localparam int unsigned S_TDATA_W =
    klkt_pkg::byte_round(klkt_pkg::IDX_W + CODE_BITS),
  localparam int unsigned M_TDATA_W = klkt_pkg::byte_round(CODE_BITS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [S_TDATA_W-1:0]              s_axis_tdata,  // entry_index, code, zero fill
  input  logic [klkt_pkg::MODE_W-1:0]       s_axis_tuser,  // mode
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [M_TDATA_W-1:0]              m_axis_tdata,  // result_code, zero fill
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [klkt_pkg::APB_AW-1:0]       paddr,
  input  logic [klkt_pkg::APB_DW-1:0]       pwdata,
  output logic [klkt_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_LAST  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // ---------------------------------------------------------------- registers
  logic tables_en_q, ctrl_mode_q;
  logic cfg_wr;
  logic cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tables_en_q <= 1'b0;
      ctrl_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        1'(klkt_pkg::REG_TABLES_EN): tables_en_q <= pwdata[0];
        1'(klkt_pkg::REG_CTRL_MODE): ctrl_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      1'(klkt_pkg::REG_TABLES_EN): prdata[0] = tables_en_q;
      1'(klkt_pkg::REG_CTRL_MODE): prdata[0] = ctrl_mode_q;
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input fields
  logic [klkt_pkg::IDX_W-1:0] in_idx;
  logic [CODE_BITS-1:0]       in_code;
  logic                       in_acc;
  logic                       in_is_wr;

  assign in_idx   = s_axis_tdata[klkt_pkg::IDX_W-1:0];
  assign in_code  = s_axis_tdata[klkt_pkg::IDX_W +: CODE_BITS];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_is_wr = (s_axis_tuser == klkt_pkg::MODE_WR_SRC) ||
                    (s_axis_tuser == klkt_pkg::MODE_WR_TGT);

  // Classify a convert key at acceptance: pass it through, or look it up, possibly
  // through its letter when control-key mode applies.
  logic in_ctrl, in_bypass;

  always_comb begin
    in_ctrl   = ctrl_mode_q && (in_code < CODE_BITS'(klkt_pkg::LETTER_COUNT));
    in_bypass = !tables_en_q
             || (in_code == '0)
             || (in_code == CODE_BITS'(klkt_pkg::CODE_SPACE))
             || (in_code == CODE_BITS'(klkt_pkg::CODE_NEWLINE))
             || (!in_ctrl && (in_code < CODE_BITS'(klkt_pkg::CTRL_LIMIT)));
  end

  // ---------------------------------------------------------------- sequencer
  logic [2:0]           state_q, state_d;
  logic [AW-1:0]        cnt_q, cnt_d;
  logic                 cmp_vld_q;
  logic                 fwd_q, ctrl_q, bypass_q;
  logic [CODE_BITS-1:0] key_q, lkey_q;
  logic                 found_q;
  logic [CODE_BITS-1:0] mapped_q;
  logic                 out_valid_q, out_valid_d;
  logic [CODE_BITS-1:0] out_data_q;
  logic                 out_load;
  logic                 rd_en;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign rd_en         = (state_q == ST_SCAN);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == LAST_ADDR) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_d = '0;
        if (in_acc && !in_is_wr) begin
          state_d = in_bypass ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == LAST_ADDR) begin
          cnt_d   = '0;
          state_d = ST_LAST;
        end
      end
      ST_LAST: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= rd_en;
    end
  end

  // Latch the key and how to treat it.
  always_ff @(posedge clk_i) begin
    if (in_acc && !in_is_wr) begin
      fwd_q    <= (s_axis_tuser == klkt_pkg::MODE_FWD);
      ctrl_q   <= in_ctrl;
      bypass_q <= in_bypass;
      key_q    <= in_code;
      lkey_q   <= in_ctrl ? in_code + CODE_BITS'(klkt_pkg::CTRL_OFFSET) : in_code;
    end
  end

  // ---------------------------------------------------------------- tables
  klkt_pkg::klkt_wr_t   tbl_wr;
  logic [AW-1:0]        tbl_wr_addr;
  logic [CODE_BITS-1:0] tbl_wr_data;
  logic [CODE_BITS-1:0] src_rd, tgt_rd;
  logic                 idx_ok;

  // Drop writes beyond the table depth.
  assign idx_ok = (32'(in_idx) < ENTRIES);

  always_comb begin
    tbl_wr      = '0;
    tbl_wr_addr = AW'(in_idx);
    tbl_wr_data = in_code;
    if (state_q == ST_CLEAR) begin
      tbl_wr.src_we = 1'b1;
      tbl_wr.tgt_we = 1'b1;
      tbl_wr_addr   = cnt_q;
      tbl_wr_data   = '0;
    end else if (in_acc && idx_ok) begin
      tbl_wr.src_we = (s_axis_tuser == klkt_pkg::MODE_WR_SRC);
      tbl_wr.tgt_we = (s_axis_tuser == klkt_pkg::MODE_WR_TGT);
    end
  end

  klkt_tables #(
    .ENTRIES   (ENTRIES),
    .CODE_BITS (CODE_BITS)
  ) u_tables (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .wr_addr_i (tbl_wr_addr),
    .wr_data_i (tbl_wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (cnt_q),
    .src_rd_o  (src_rd),
    .tgt_rd_o  (tgt_rd)
  );

  // ---------------------------------------------------------------- match accumulation
  // Tables are written only while idle or during the clearing pass, so a scan never races a write.
  logic [CODE_BITS-1:0] srch_val, ans_val;
  logic                 hit;

  assign srch_val = fwd_q ? src_rd : tgt_rd;
  assign ans_val  = fwd_q ? tgt_rd : src_rd;
  assign hit      = cmp_vld_q && (srch_val != '0) && (srch_val == lkey_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (in_acc) begin
      found_q <= 1'b0;
    end else if (hit) begin
      found_q <= 1'b1;
    end
  end

  // Keep the answer of the last match whose answer is nonzero.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mapped_q <= '0;
    end else if (hit && (ans_val != '0)) begin
      mapped_q <= ans_val;
    end
  end

  // ---------------------------------------------------------------- result
  logic [CODE_BITS-1:0] lookup_res, ctrl_res, final_res;

  always_comb begin
    lookup_res = found_q ? mapped_q : lkey_q;
    if ((lookup_res >= CODE_BITS'(klkt_pkg::CTRL_OFFSET + 1)) &&
        (lookup_res <= CODE_BITS'(klkt_pkg::CTRL_OFFSET + klkt_pkg::LETTER_COUNT - 1))) begin
      ctrl_res = lookup_res - CODE_BITS'(klkt_pkg::CTRL_OFFSET);
    end else begin
      ctrl_res = '0;
    end
    priority if (bypass_q) begin
      final_res = key_q;
    end else if (ctrl_q) begin
      final_res = ctrl_res;
    end else begin
      final_res = lookup_res;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= final_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_data_q);

endmodule

// ----- hdl/klkt_checker.sv -----
// Port-level checks of the key translator and their binding to the top level.
`include "keyboard_layout_key_translator_core_defines.svh"

module klkt_checker #(
  parameter int unsigned CODE_BITS  = klkt_pkg::CODE_BITS_DEF,
  localparam int unsigned S_TDATA_W =
    klkt_pkg::byte_round(klkt_pkg::IDX_W + CODE_BITS),
  localparam int unsigned M_TDATA_W = klkt_pkg::byte_round(CODE_BITS)
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [S_TDATA_W-1:0]        s_axis_tdata,
  input logic [klkt_pkg::MODE_W-1:0] s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [M_TDATA_W-1:0]        m_axis_tdata
);

  logic s_acc, s_wr;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign s_wr  = (s_axis_tuser == klkt_pkg::MODE_WR_SRC) ||
                 (s_axis_tuser == klkt_pkg::MODE_WR_TGT);

  // The clearing pass holds the input closed right after reset.
  `KLKT_ASSERT_NOW(a_clear_blocks_input, $rose(rst_ni), !s_axis_tready, "input open during clear")

  // A table write completes in its own cycle.
  `KLKT_ASSERT_NEXT(a_write_keeps_ready, s_acc && s_wr, s_axis_tready, "write stalled input")

  // A convert occupies the block until its result is loaded.
  `KLKT_ASSERT_NEXT(a_convert_busy, s_acc && !s_wr, !s_axis_tready, "convert left input open")

  // A stalled result holds.
  `KLKT_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind keyboard_layout_key_translator_core klkt_checker #(
  .CODE_BITS (CODE_BITS)
) u_klkt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/tb.sv -----
// Self-checking stream testbench for the keyboard layout key translator core.
`timescale 1ns / 100ps

module tb;
  import klkt_pkg::*;

  localparam int unsigned ENTRIES     = ENTRIES_DEF;
  localparam int unsigned CODE_W      = CODE_BITS_DEF;
  localparam int unsigned S_TDATA_W   = byte_round(IDX_W + CODE_W);
  localparam int unsigned M_TDATA_W   = byte_round(CODE_W);
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 205;
  localparam int unsigned WR_SETTLE   = 8;     // lets a trailing table write land
  localparam int unsigned HOLD_AFTER  = 40;    // results seen before the long hold-off
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam longint     LIMIT_NS    = 2_000_000;

  // Letter code points used by the directed part
  localparam logic [CODE_W-1:0] KEY_A = CODE_W'(CTRL_OFFSET + 1);
  localparam logic [CODE_W-1:0] KEY_B = CODE_W'(CTRL_OFFSET + 2);
  localparam logic [CODE_W-1:0] KEY_C = CODE_W'(CTRL_OFFSET + 3);
  localparam logic [CODE_W-1:0] KEY_Q = CODE_W'(CTRL_OFFSET + 17);

  // Holds both layout tables and the registers, predicts each translated key
  // and compares the codes that come out of the block against that prediction.
  class key_translation_sb;
    logic [CODE_W-1:0] src_tab [ENTRIES];
    logic [CODE_W-1:0] tgt_tab [ENTRIES];
    bit                tables_en;
    bit                ctrl_mode;
    logic [CODE_W-1:0] expected_codes [$];
    int unsigned       mismatches;
    int unsigned       results_seen;

    function new();
      foreach (src_tab[i]) begin
        src_tab[i] = '0;
        tgt_tab[i] = '0;
      end
      tables_en    = 1'b0;
      ctrl_mode    = 1'b0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_register(int unsigned reg_idx, bit val);
      if (reg_idx == REG_TABLES_EN) begin
        tables_en = val;
      end else if (reg_idx == REG_CTRL_MODE) begin
        ctrl_mode = val;
      end
    endfunction

    // Last nonzero answer among the matches wins; matches that all map to
    // zero give zero; no match at all leaves the key as it is.
    function logic [CODE_W-1:0] search_tables(logic [CODE_W-1:0] key, bit fwd);
      logic [CODE_W-1:0] hit;
      logic [CODE_W-1:0] probe;
      logic [CODE_W-1:0] other;
      bit                found;
      hit   = '0;
      found = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        probe = fwd ? src_tab[i] : tgt_tab[i];
        other = fwd ? tgt_tab[i] : src_tab[i];
        if (probe != '0 && probe == key) begin
          if (other != '0) hit = other;
          found = 1'b1;
        end
      end
      return found ? hit : key;
    endfunction

    function logic [CODE_W-1:0] translate_key(logic [CODE_W-1:0] key, bit fwd);
      longint letter;
      if (!tables_en) return key;
      if (key == 0 || key == CODE_SPACE || key == CODE_NEWLINE) return key;
      if (key < LETTER_COUNT && ctrl_mode) begin
        letter = longint'(search_tables(CODE_W'(key + CTRL_OFFSET), fwd))
                 - longint'(CTRL_OFFSET);
        return (letter > 0 && letter < LETTER_COUNT) ? CODE_W'(letter) : '0;
      end
      if (key < CTRL_LIMIT) return key;
      return search_tables(key, fwd);
    endfunction

    function void take_item(klkt_mode_e mode, logic [IDX_W-1:0] idx,
                            logic [CODE_W-1:0] code);
      case (mode)
        MODE_WR_SRC: src_tab[idx] = code;
        MODE_WR_TGT: tgt_tab[idx] = code;
        MODE_FWD:    expected_codes.push_back(translate_key(code, 1'b1));
        default:     expected_codes.push_back(translate_key(code, 1'b0));
      endcase
    endfunction

    function void check_result_code(logic [CODE_W-1:0] got);
      logic [CODE_W-1:0] want;
      results_seen++;
      if (expected_codes.size() == 0) begin
        mismatches++;
        $error("result_code: none expected, got %0h", got);
        return;
      end
      want = expected_codes.pop_front();
      if (want !== got) begin
        mismatches++;
        $error("result_code: expected %0h, got %0h", want, got);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // entry_index, code, zero fill
  logic [MODE_W-1:0]    s_axis_tuser;   // mode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // result_code, zero fill
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  key_translation_sb sb = new();
  bit idle_on = 1'b1;   // random gaps on both sides; cleared for the last phase

  keyboard_layout_key_translator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop, far beyond the slowest correct run
  initial begin
    #(LIMIT_NS);
    $display("tb failed");
    $finish;
  end

  // Offer one transaction and hold it until the block takes it. An optional
  // short gap goes first; valid stays high afterwards so that back-to-back
  // transactions keep a single assignment per edge.
  task automatic send_item(klkt_mode_e mode, logic [IDX_W-1:0] idx,
                           logic [CODE_W-1:0] code);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {{(S_TDATA_W - IDX_W - CODE_W){1'b0}}, code, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_item(mode, idx, code);
  endtask

  // Drop valid, wait for every outstanding translation, then let a trailing
  // table write finish so that the block is truly idle.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_codes.size() != 0) @(posedge clk_i);
    repeat (WR_SETTLE) @(posedge clk_i);
  endtask

  // Setup cycle then access cycle; pready is tied high so the access lands
  // at the end of the access cycle. Leave the bus idle afterwards.
  task automatic write_reg(int unsigned reg_idx, bit val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= APB_AW'(reg_idx * 4);
    pwdata  <= APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    sb.set_register(reg_idx, val);
  endtask

  // Code points to store: mostly letters and a small crowded pool, so that
  // lookups find several matches, plus zero, low codes and full-width values.
  function automatic logic [CODE_W-1:0] stored_code();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CODE_W'($urandom_range(CTRL_OFFSET + 1, CTRL_OFFSET + LETTER_COUNT));
      4:          return CODE_W'($urandom_range(0, 40));
      5:          return '0;
      6:          return CODE_W'($urandom);
      7:          return '1;
      default:    return CODE_W'($urandom_range(200, 215));
    endcase
  endfunction

  // Keys to translate: often a value that already sits in the searched table.
  function automatic logic [CODE_W-1:0] probe_key(bit fwd);
    int unsigned row;
    row = $urandom_range(0, ENTRIES - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return fwd ? sb.src_tab[row] : sb.tgt_tab[row];
      4, 5:       return CODE_W'($urandom_range(1, LETTER_COUNT - 1));
      6:          return CODE_W'($urandom_range(0, 40));
      7:          return CODE_W'($urandom);
      default:    return stored_code();
    endcase
  endfunction

  // Result side: check every transaction, stall in short bursts, and once
  // hold off for a long stretch so that the block backs up into its input.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    bit          held;
    bit          ready_nxt;
    stall_left    = 0;
    hold_left     = 0;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        sb.check_result_code(m_axis_tdata[CODE_W-1:0]);
      end
      if (!held && sb.results_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        ready_nxt = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        ready_nxt = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        ready_nxt  = 1'b0;
      end else begin
        ready_nxt = 1'b1;
      end
      m_axis_tready <= ready_nxt;
    end
  end

  initial begin : stimulus
    bit          phase_en   [PHASES];
    bit          phase_ctrl [PHASES];
    int unsigned pick;
    bit          fwd;
    logic [IDX_W-1:0] row;

    phase_en      = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_ctrl    = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_WR_SRC;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Load a few mappings while the tables are still switched off: a letter
    // pair, the extreme entry with the largest code, a key whose only match
    // maps to nothing, a letter that maps outside the letters, and one key
    // with three matches where the last one maps to zero.
    send_item(MODE_WR_SRC, 0, KEY_A);
    send_item(MODE_WR_TGT, 0, KEY_Q);
    send_item(MODE_WR_SRC, '1, '1);
    send_item(MODE_WR_TGT, '1, 1);
    send_item(MODE_WR_SRC, 5, KEY_B);
    send_item(MODE_WR_SRC, 10, KEY_C);
    send_item(MODE_WR_TGT, 10, 200);
    send_item(MODE_WR_SRC, 20, 500);
    send_item(MODE_WR_TGT, 20, 600);
    send_item(MODE_WR_SRC, 21, 500);
    send_item(MODE_WR_TGT, 21, 700);
    send_item(MODE_WR_SRC, 22, 500);
    // Tables disabled: the key comes back untouched
    send_item(MODE_FWD, 0, KEY_A);

    settle_block();
    write_reg(REG_TABLES_EN, 1'b1);
    send_item(MODE_FWD, 0, KEY_A);
    send_item(MODE_BWD, 0, KEY_Q);
    send_item(MODE_FWD, 0, KEY_B);
    send_item(MODE_FWD, 0, 500);
    send_item(MODE_BWD, '1, 600);
    send_item(MODE_FWD, 0, CODE_W'(CODE_SPACE));
    send_item(MODE_FWD, 0, CODE_W'(CODE_NEWLINE));
    send_item(MODE_FWD, 0, 0);
    send_item(MODE_FWD, 0, 1);                    // low code, control mode off
    send_item(MODE_FWD, 0, CODE_W'(CTRL_LIMIT));  // first code that is looked up
    send_item(MODE_BWD, 0, '1);

    // Control codes go through their letters
    settle_block();
    write_reg(REG_CTRL_MODE, 1'b1);
    send_item(MODE_FWD, 0, 1);
    send_item(MODE_FWD, 0, 3);
    send_item(MODE_FWD, 0, 2);
    send_item(MODE_FWD, 0, CODE_W'(LETTER_COUNT));

    // Random phases, each under its own register setting; the last runs
    // without any idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      settle_block();
      write_reg(REG_TABLES_EN, phase_en[p]);
      write_reg(REG_CTRL_MODE, phase_ctrl[p]);
      if (p == PHASES - 1) idle_on = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 9);
        row  = IDX_W'($urandom_range(0, ENTRIES - 1));
        if (pick < 4) begin
          send_item(pick < 2 ? MODE_WR_SRC : MODE_WR_TGT, row, stored_code());
        end else begin
          fwd = (pick < 7);
          send_item(fwd ? MODE_FWD : MODE_BWD, row, probe_key(fwd));
        end
      end
    end

    // Drain, then give the block time to show any stray result
    settle_block();
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_codes.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/klkt_pkg.sv
hdl/klkt_tables.sv
hdl/keyboard_layout_key_translator_core.sv
hdl/klkt_checker.sv
tb/sv/tb.sv
